/* design/cmsq_pkg.sv */
// ============================================================================
// Complex magnitude sorted queue: shared package
// Widths, status codes, controller states and the command and status
// structures that pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package cmsq_pkg;

    // Number of list cells.
    localparam int LIST_DEPTH = 16;
    // Width of one real or imaginary part.
    localparam int PART_WIDTH = 16;
    // Squared magnitude width. re*re + im*im is at most 2**(2*PART_WIDTH-1).
    localparam int MAG_W = 2 * PART_WIDTH;
    // Entry count width; it must hold LIST_DEPTH itself.
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    // Scan position width.
    localparam int IDX_W = $clog2(LIST_DEPTH);

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_MATCH    = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_FLUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input item and square its parts
        logic insert;   // place the captured value into the cell chain
        logic rotate;   // rotate the chain by one cell and test cell zero
        logic flush;    // emit the held match, or the none-matched result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;    // this rotation is the last of the pass
    } t_stat;

endpackage

`default_nettype wire

/* design/cmsq_ctrl.sv */
// ============================================================================
// Complex magnitude sorted queue: controller
// State machine that accepts items and sequences the insert, scan and flush
// steps of the datapath.
// ============================================================================
`default_nettype none

module cmsq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire logic            i_operation,
    input  wire cmsq_pkg::t_stat i_stat,
    output logic                 busy,
    output cmsq_pkg::t_cmd       o_cmd
);

    cmsq_pkg::t_state r_state;
    cmsq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmsq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cmsq_pkg::S_IDLE: begin
                if (start) begin
                    if (i_operation == cmsq_pkg::OP_READ) begin
                        n_state = cmsq_pkg::S_SCAN;
                    end else begin
                        n_state = cmsq_pkg::S_INSERT;
                    end
                end
            end
            cmsq_pkg::S_INSERT: begin
                n_state = cmsq_pkg::S_IDLE;
            end
            cmsq_pkg::S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = cmsq_pkg::S_FLUSH;
                end
            end
            cmsq_pkg::S_FLUSH: begin
                n_state = cmsq_pkg::S_IDLE;
            end
            default: begin
                n_state = cmsq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            cmsq_pkg::S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            cmsq_pkg::S_INSERT: begin
                o_cmd.insert = 1'b1;
            end
            cmsq_pkg::S_SCAN: begin
                o_cmd.rotate = 1'b1;
            end
            cmsq_pkg::S_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/cmsq_dpath.sv */
// ============================================================================
// Complex magnitude sorted queue: datapath
// Shifting cell chain holding the sorted entries with their squared
// magnitudes, the input squarers, the scan counter and the result registers.
// ============================================================================
`default_nettype none

module cmsq_dpath (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire cmsq_pkg::t_cmd                         i_cmd,
    input  wire logic signed [cmsq_pkg::PART_WIDTH-1:0] i_value_re,
    input  wire logic signed [cmsq_pkg::PART_WIDTH-1:0] i_value_im,
    output cmsq_pkg::t_stat                             o_stat,
    output logic                                        o_valid,
    output logic             [1:0]                      o_status,
    output logic signed      [cmsq_pkg::PART_WIDTH-1:0] o_entry_re,
    output logic signed      [cmsq_pkg::PART_WIDTH-1:0] o_entry_im,
    output logic                                        o_last
);

    localparam int D  = cmsq_pkg::LIST_DEPTH;
    localparam int PW = cmsq_pkg::PART_WIDTH;
    localparam int MW = cmsq_pkg::MAG_W;
    localparam int CW = cmsq_pkg::CNT_W;
    localparam int IW = cmsq_pkg::IDX_W;

    // Captured input item.
    logic [PW-1:0] r_in_re;
    logic [PW-1:0] r_in_im;
    logic [MW-1:0] r_sq_re;
    logic [MW-1:0] r_sq_im;

    // Cell chain. Cells below r_count hold valid entries in list order.
    logic [PW-1:0] r_cell_re  [D];
    logic [PW-1:0] r_cell_im  [D];
    logic [MW-1:0] r_cell_mag [D];
    logic [PW-1:0] n_cell_re  [D];
    logic [PW-1:0] n_cell_im  [D];
    logic [MW-1:0] n_cell_mag [D];
    logic [CW-1:0] r_count;

    // Scan state.
    logic [IW-1:0] r_k;
    logic          r_pend_v;
    logic [PW-1:0] r_pend_re;
    logic [PW-1:0] r_pend_im;

    // Result registers.
    logic          r_out_v;
    logic [1:0]    r_out_status;
    logic [PW-1:0] r_out_re;
    logic [PW-1:0] r_out_im;
    logic          r_out_last;

    logic signed [MW-1:0] sq_re_full;
    logic signed [MW-1:0] sq_im_full;
    logic [MW-1:0]        new_mag;
    logic [D-1:0]         gt;
    logic                 full;
    logic                 match;

    assign sq_re_full = i_value_re * i_value_re;
    assign sq_im_full = i_value_im * i_value_im;
    assign new_mag    = r_sq_re + r_sq_im;
    assign full       = (r_count == CW'(D));
    assign match      = (CW'(r_k) < r_count) && r_cell_re[0][PW-1];

    assign o_stat.scan_done = (r_k == IW'(D - 1));

    // A cell is passed over when it is valid and smaller than the new value.
    // The list is sorted, so these bits form a prefix.
    always_comb begin
        for (int i = 0; i < D; i++) begin
            gt[i] = (CW'(i) < r_count) && (new_mag > r_cell_mag[i]);
        end
    end

    // Next cell contents for insert and rotate.
    always_comb begin
        for (int i = 0; i < D; i++) begin
            n_cell_re[i]  = r_cell_re[i];
            n_cell_im[i]  = r_cell_im[i];
            n_cell_mag[i] = r_cell_mag[i];
        end
        if (i_cmd.insert && !full) begin
            if (!gt[0]) begin
                n_cell_re[0]  = r_in_re;
                n_cell_im[0]  = r_in_im;
                n_cell_mag[0] = new_mag;
            end
            for (int i = 1; i < D; i++) begin
                if (!gt[i - 1]) begin
                    n_cell_re[i]  = r_cell_re[i - 1];
                    n_cell_im[i]  = r_cell_im[i - 1];
                    n_cell_mag[i] = r_cell_mag[i - 1];
                end else if (!gt[i]) begin
                    n_cell_re[i]  = r_in_re;
                    n_cell_im[i]  = r_in_im;
                    n_cell_mag[i] = new_mag;
                end
            end
        end else if (i_cmd.rotate) begin
            for (int i = 0; i < D - 1; i++) begin
                n_cell_re[i]  = r_cell_re[i + 1];
                n_cell_im[i]  = r_cell_im[i + 1];
                n_cell_mag[i] = r_cell_mag[i + 1];
            end
            n_cell_re[D - 1]  = r_cell_re[0];
            n_cell_im[D - 1]  = r_cell_im[0];
            n_cell_mag[D - 1] = r_cell_mag[0];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < D; i++) begin
            r_cell_re[i]  <= n_cell_re[i];
            r_cell_im[i]  <= n_cell_im[i];
            r_cell_mag[i] <= n_cell_mag[i];
        end
        if (i_cmd.load) begin
            r_in_re <= i_value_re;
            r_in_im <= i_value_im;
            r_sq_re <= sq_re_full;
            r_sq_im <= sq_im_full;
        end
        if (i_cmd.rotate && match) begin
            r_pend_re <= r_cell_re[0];
            r_pend_im <= r_cell_im[0];
        end
    end

    // Control registers and results. A match is held back by one so that the
    // final one can be flagged when the pass ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_k          <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
            r_out_status <= cmsq_pkg::ST_INSERTED;
            r_out_re     <= '0;
            r_out_im     <= '0;
            r_out_last   <= 1'b0;
        end else begin
            r_out_v      <= 1'b0;
            r_out_re     <= '0;
            r_out_im     <= '0;
            r_out_last   <= 1'b1;
            if (i_cmd.load) begin
                r_k      <= '0;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.insert) begin
                r_out_v <= 1'b1;
                if (full) begin
                    r_out_status <= cmsq_pkg::ST_FULL;
                end else begin
                    r_out_status <= cmsq_pkg::ST_INSERTED;
                    r_count      <= r_count + CW'(1);
                end
            end
            if (i_cmd.rotate) begin
                r_k <= r_k + IW'(1);
                if (match) begin
                    r_pend_v <= 1'b1;
                    if (r_pend_v) begin
                        r_out_v      <= 1'b1;
                        r_out_status <= cmsq_pkg::ST_MATCH;
                        r_out_re     <= r_pend_re;
                        r_out_im     <= r_pend_im;
                        r_out_last   <= 1'b0;
                    end
                end
            end
            if (i_cmd.flush) begin
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
                if (r_pend_v) begin
                    r_out_status <= cmsq_pkg::ST_MATCH;
                    r_out_re     <= r_pend_re;
                    r_out_im     <= r_pend_im;
                end else begin
                    r_out_status <= cmsq_pkg::ST_NONE;
                end
            end
        end
    end

    assign o_valid    = r_out_v;
    assign o_status   = r_out_status;
    assign o_entry_re = r_out_re;
    assign o_entry_im = r_out_im;
    assign o_last     = r_out_last;

endmodule

`default_nettype wire

/* design/complex_magnitude_sorted_queue.sv */
// ============================================================================
// Complex magnitude sorted queue
// Bounded list of complex integers kept in ascending order of squared
// magnitude, with insert and read-negative-real-part operations.
// ============================================================================
//
// Channel   Direction  Signals                                   Transfer
// -------   ---------  ----------------------------------------  --------------------
// item      in         i_operation, i_value_re, i_value_im       start high, busy low
// result    out        o_status, o_entry_re, o_entry_im, o_last  o_valid high
//
// On an insert, the accept cycle squares both parts into registers, and the
// next cycle adds them, compares the sum against the stored magnitude of
// every cell at once and shifts the chain to open the slot.
// On a read, the chain rotates by one cell per cycle through a full turn, so
// its order is restored, and a last cycle flushes the final match.
// Reset is synchronous and active low; it empties the list. The receiver
// cannot stall: each result is shown for exactly one cycle on o_valid.
// ============================================================================
`default_nettype none

module complex_magnitude_sorted_queue (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   i_operation,
    input  wire logic signed [cmsq_pkg::PART_WIDTH-1:0] i_value_re,
    input  wire logic signed [cmsq_pkg::PART_WIDTH-1:0] i_value_im,
    output logic                                        o_valid,
    output logic             [1:0]                      o_status,
    output logic signed      [cmsq_pkg::PART_WIDTH-1:0] o_entry_re,
    output logic signed      [cmsq_pkg::PART_WIDTH-1:0] o_entry_im,
    output logic                                        o_last
);

    // Command and status between the controller and the datapath.
    cmsq_pkg::t_cmd  cmd;
    cmsq_pkg::t_stat stat;

    // The controller accepts an item only in its idle state, then walks
    // through insert, or through scan and flush for a read.
    cmsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .busy        (busy),
        .o_cmd       (cmd)
    );

    // The datapath owns the cell chain and registers every result, so each
    // transfer on the result side comes straight from flip-flops.
    cmsq_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value_re (i_value_re),
        .i_value_im (i_value_im),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_entry_re (o_entry_re),
        .o_entry_im (o_entry_im),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

/* dv/tb_complex_magnitude_sorted_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the complex magnitude sorted queue
// Drives insert and read commands through the start/busy handshake and keeps
// a shadow copy of the sorted list. Every strobed result is checked, field by
// field, against the oldest outstanding prediction. A directed pass covers the
// empty read, magnitude ties and the part extremes. A long random pass then
// fills the list, runs into full refusals and streams reads of every length.
// ============================================================================

module tb_complex_magnitude_sorted_queue;

    localparam int PW             = cmsq_pkg::PART_WIDTH;
    localparam int DEPTH          = cmsq_pkg::LIST_DEPTH;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 210;
    // The last items of the random pass are sent back to back.
    localparam int TAIL_ITEMS     = 60;
    // This tail is longer than a read, so it covers one.
    localparam int TAIL_CYCLES    = DEPTH + 8;
    // Longest legal quiet stretch is the longest sender gap plus one read.
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic signed [PW-1:0] PART_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [PW-1:0] PART_MAX = {1'b0, {(PW-1){1'b1}}};

    // One result as the block should present it.
    typedef struct {
        logic [1:0]           status;
        logic signed [PW-1:0] re;
        logic signed [PW-1:0] im;
        logic                 last;
    } t_list_result;

    // ------------------------------------------------------------------------
    // Block inputs start at known values before the first clock edge.
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  i_operation = cmsq_pkg::OP_INSERT;
    logic signed [PW-1:0]  i_value_re  = '0;
    logic signed [PW-1:0]  i_value_im  = '0;

    logic                  busy;
    logic                  o_valid;
    logic        [1:0]     o_status;
    logic signed [PW-1:0]  o_entry_re;
    logic signed [PW-1:0]  o_entry_im;
    logic                  o_last;

    // Shadow copy of the list, in list order, plus the results still owed.
    logic signed [PW-1:0]  shadow_re [DEPTH];
    logic signed [PW-1:0]  shadow_im [DEPTH];
    int                    shadow_count = 0;
    t_list_result          list_results_due [$];

    // Bookkeeping for the closing summary.
    int  mismatch_count  = 0;
    int  items_sent      = 0;
    int  inserts_stored  = 0;
    int  full_refusals   = 0;
    int  reads_sent      = 0;
    int  results_checked = 0;
    int  matches_seen    = 0;
    int  stall_cycles    = 0;
    // When set, the sender now and then idles for a random burst.
    bit  gaps_on         = 1'b1;

    complex_magnitude_sorted_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value_re  (i_value_re),
        .i_value_im  (i_value_im),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_entry_re  (o_entry_re),
        .o_entry_im  (o_entry_im),
        .o_last      (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Squared magnitude, wide enough that no pair of parts can overflow it.
    // ------------------------------------------------------------------------
    function automatic longint squared_magnitude(input logic signed [PW-1:0] re,
                                                 input logic signed [PW-1:0] im);
        longint a;
        longint b;
        a = re;
        b = im;
        return a * a + b * b;
    endfunction

    // Append one owed result at the back of the queue.
    function automatic void owe_result(input t_list_result res);
        list_results_due = {list_results_due, res};
    endfunction

    // ------------------------------------------------------------------------
    // Apply one accepted command to the shadow list and queue the results it
    // owes. An insert goes in front of the first entry whose magnitude is not
    // smaller, so a new value lands ahead of older entries of equal
    // magnitude. A read owes every entry with a negative real part, in list
    // order, with the last one flagged, or a single none-matched result.
    // ------------------------------------------------------------------------
    function automatic void apply_list_op(input logic op,
                                          input logic signed [PW-1:0] re,
                                          input logic signed [PW-1:0] im);
        t_list_result res;
        longint       mag;
        int           pos;
        int           n;
        res.re   = '0;
        res.im   = '0;
        res.last = 1'b1;
        if (op == cmsq_pkg::OP_INSERT) begin
            if (shadow_count >= DEPTH) begin
                // A full list refuses the value and stays as it is.
                res.status = cmsq_pkg::ST_FULL;
                full_refusals++;
            end else begin
                mag = squared_magnitude(re, im);
                pos = 0;
                while (pos < shadow_count && mag > squared_magnitude(shadow_re[pos],
                                                                     shadow_im[pos]))
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_re[i] = shadow_re[i-1];
                    shadow_im[i] = shadow_im[i-1];
                end
                shadow_re[pos] = re;
                shadow_im[pos] = im;
                shadow_count++;
                res.status = cmsq_pkg::ST_INSERTED;
                inserts_stored++;
            end
            owe_result(res);
        end else begin
            // The value fields of a read carry no meaning.
            n = 0;
            for (int i = 0; i < shadow_count; i++) begin
                if (shadow_re[i] < 0) begin
                    res.status = cmsq_pkg::ST_MATCH;
                    res.re     = shadow_re[i];
                    res.im     = shadow_im[i];
                    res.last   = 1'b0;
                    owe_result(res);
                    n++;
                end
            end
            if (n == 0) begin
                res.status = cmsq_pkg::ST_NONE;
                owe_result(res);
            end else begin
                list_results_due[list_results_due.size()-1].last = 1'b1;
            end
            reads_sent++;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Send one command. With gaps enabled the sender may first drop start for a
    // random burst. Start is then raised with the payload and held until an
    // edge sees busy low, which is the transfer. Start is left high on return;
    // the caller either sends again at once or lowers it.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op,
                             input logic signed [PW-1:0] re,
                             input logic signed [PW-1:0] im);
        int gap;
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_value_re  <= re;
        i_value_im  <= im;
        do
            @(posedge i_clk);
        while (busy);
        apply_list_op(op, re, im);
        items_sent++;
    endtask

    // One random part: small values make magnitude ties likely, a share hit
    // the extremes, and the rest cover the whole range.
    function automatic logic signed [PW-1:0] pick_part();
        int v;
        case ($urandom_range(0, 3))
            0: begin
                v = int'($urandom_range(0, 16)) - 8;
                return v[PW-1:0];
            end
            1: return $urandom_range(0, 1) ? PART_MIN : PART_MAX;
            default: begin
                v = $urandom();
                return v[PW-1:0];
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // A read of the empty list gives a single none-matched result; the value
    // fields are set to the extremes to show they are ignored.
    task automatic test_read_empty();
        send_item(cmsq_pkg::OP_READ, PART_MIN, PART_MAX);
    endtask

    // Equal magnitudes (3,4), (-4,3) and (0,-5) must stack newest first.
    // Zero, the most negative pair and a mixed extreme pair check the ends
    // of the magnitude range. Reads in between show the ordering so far.
    task automatic test_insert_order();
        send_item(cmsq_pkg::OP_INSERT, 16'sd3, 16'sd4);
        send_item(cmsq_pkg::OP_INSERT, -16'sd4, 16'sd3);
        send_item(cmsq_pkg::OP_READ, PART_MAX, PART_MIN);
        send_item(cmsq_pkg::OP_INSERT, 16'sd0, 16'sd0);
        send_item(cmsq_pkg::OP_INSERT, PART_MIN, PART_MIN);
        send_item(cmsq_pkg::OP_INSERT, PART_MAX, PART_MIN);
        send_item(cmsq_pkg::OP_INSERT, -16'sd1, 16'sd0);
        send_item(cmsq_pkg::OP_INSERT, 16'sd0, -16'sd5);
        send_item(cmsq_pkg::OP_READ, PART_MAX, -16'sd1);
    endtask

    // Random inserts and reads in equal measure. The list fills within the
    // first few dozen items; after that inserts must be refused while reads
    // keep streaming the full list. Idle bursts stop for the closing items.
    task automatic test_random_traffic();
        logic op;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            gaps_on = (k < RANDOM_ITEMS - TAIL_ITEMS);
            op = $urandom_range(0, 1) ? cmsq_pkg::OP_READ : cmsq_pkg::OP_INSERT;
            send_item(op, pick_part(), pick_part());
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker. The receiver cannot stall, so every edge that sees
    // o_valid high completes one transfer, compared with the oldest entry owed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_list_result due;
        if (i_rst_n && o_valid) begin
            results_checked++;
            if (list_results_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed: status %0d re %0d im %0d",
                                          o_status, o_entry_re, o_entry_im));
            end else begin
                due = list_results_due.pop_front();
                if (due.status == cmsq_pkg::ST_MATCH)
                    matches_seen++;
                if (o_status !== due.status)
                    report_mismatch($sformatf("status %0d, wanted %0d", o_status, due.status));
                if (o_entry_re !== due.re)
                    report_mismatch($sformatf("entry_re %0d, wanted %0d", o_entry_re, due.re));
                if (o_entry_im !== due.im)
                    report_mismatch($sformatf("entry_im %0d, wanted %0d", o_entry_im, due.im));
                if (o_last !== due.last)
                    report_mismatch($sformatf("last %0b, wanted %0b", o_last, due.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any command or result transfer clears the count; a long
    // enough stretch with neither means the block has hung.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results still owed",
                     list_results_due.size());
            $display("complex_magnitude_sorted_queue test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset once, run the tests, drain, then report.
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_read_empty();
        test_insert_order();
        test_random_traffic();

        // No more commands: drop start, wait for every owed result, then give
        // the block a read's worth of cycles to show any stray result.
        start <= 1'b0;
        while (list_results_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands: %0d inserts stored, %0d refused as full, %0d reads.",
                 items_sent, inserts_stored, full_refusals, reads_sent);
        $display("Checked %0d results (%0d matching entries), %0d mismatches.",
                 results_checked, matches_seen, mismatch_count);
        if (mismatch_count == 0 && list_results_due.size() == 0)
            $display("complex_magnitude_sorted_queue test passed");
        else
            $display("complex_magnitude_sorted_queue test failed");
        $finish;
    end

endmodule
